// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent must hold whenever the antecedent holds
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: design/lspc_pkg.sv
// ----------------------------------------------------------------------------
// lspc_pkg
// Shared types, widths and constants of the laser scan polar-to-cartesian
// converter.
// ----------------------------------------------------------------------------
package lspc_pkg;

    localparam int RANGE_W  = 16;
    localparam int ANGLE_W  = 16;
    localparam int POINT_W  = 17;
    localparam int BEAM_W   = 12;
    localparam int CFG_W    = 16;
    localparam int CFG_ADDR_W = 2;

    localparam int GAIN_W   = 30;
    localparam int PROD_W   = RANGE_W + GAIN_W;
    localparam int X_W      = 36;
    localparam int Z_W      = 34;
    localparam int ATAN_W   = 30;
    localparam int ATAN_LEN = 24;

    localparam int MAX_BEAMS_DEF     = 4096;
    localparam int CORDIC_STAGES_DEF = 16;

    // CORDIC gain compensation, Q30
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;

    localparam logic signed [POINT_W-1:0] POINT_MAX = 17'sd65535;
    localparam logic signed [POINT_W-1:0] POINT_MIN = -17'sd65535;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_ANGLE = 2'd0,
        CFG_ANGLE_STEP  = 2'd1,
        CFG_MAX_RANGE   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] y;
        logic signed [Z_W-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range;
        logic [ANGLE_W-1:0] angle;
        logic [BEAM_W-1:0]  number;
    } beam_t;

    // arctan(2^-i) in units of 2^32 per turn
    function automatic logic [ATAN_W-1:0] atan_val(input int unsigned i);
        logic [ATAN_W-1:0] v;
        case (i)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667331;
            5:  v = 30'd21354465;
            6:  v = 30'd10680862;
            7:  v = 30'd5341269;
            8:  v = 30'd2670675;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            16: v = 30'd10430;
            17: v = 30'd5215;
            18: v = 30'd2608;
            19: v = 30'd1304;
            20: v = 30'd652;
            21: v = 30'd326;
            22: v = 30'd163;
            23: v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: design/lspc_front.sv
// ----------------------------------------------------------------------------
// lspc_front
// Beam index and angle tracking, range filter, gain multiply and quadrant
// fold. Two register stages feeding the first CORDIC cell.
// ----------------------------------------------------------------------------
module lspc_front #(
    parameter int BEAM_LIMIT = lspc_pkg::MAX_BEAMS_DEF - 1
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  logic                            accept,
    input  logic [lspc_pkg::RANGE_W-1:0]    range_mm,
    input  logic                            range_finite,
    input  logic                            scan_start,
    input  logic                            cfg_wr_en,
    input  logic [lspc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lspc_pkg::CFG_W-1:0]      cfg_wdata,
    output logic                            out_valid,
    output lspc_pkg::vec_t                  out_vec,
    output lspc_pkg::beam_t                 out_beam
);

    localparam logic [lspc_pkg::BEAM_W-1:0] LIMIT = lspc_pkg::BEAM_W'(BEAM_LIMIT);

    logic [lspc_pkg::ANGLE_W-1:0] start_angle_reg;
    logic [lspc_pkg::ANGLE_W-1:0] angle_step_reg;
    logic [lspc_pkg::RANGE_W-1:0] max_range_reg;
    logic [lspc_pkg::ANGLE_W-1:0] acc_reg, acc_next;
    logic [lspc_pkg::BEAM_W-1:0]  cnt_reg, cnt_next;

    logic [lspc_pkg::BEAM_W-1:0]  idx;
    logic [lspc_pkg::ANGLE_W-1:0] off;
    logic [lspc_pkg::ANGLE_W-1:0] ang;
    logic                         flip;
    logic                         keep;
    logic signed [lspc_pkg::ANGLE_W-1:0] res_ang;

    // stage A
    logic                          a_valid_reg;
    logic [lspc_pkg::PROD_W-1:0]   a_prod_reg;
    logic                          a_flip_reg;
    logic signed [lspc_pkg::Z_W-1:0] a_z_reg;
    lspc_pkg::beam_t               a_beam_reg;

    // stage B
    logic                          b_valid_reg;
    lspc_pkg::vec_t                b_vec_reg;
    lspc_pkg::beam_t               b_beam_reg;

    logic signed [lspc_pkg::X_W-1:0] x0;

    always_comb begin
        idx  = scan_start ? '0 : cnt_reg;
        off  = scan_start ? '0 : acc_reg;
        ang  = start_angle_reg + off;
        flip = ang[15] ^ ang[14];
        res_ang = {ang[15] ^ flip, ang[14:0]};
        keep = range_finite && (range_mm < max_range_reg);
        if (idx < LIMIT) begin
            cnt_next = idx + 1'b1;
            acc_next = off + angle_step_reg;
        end else begin
            cnt_next = idx;
            acc_next = off;
        end
        x0 = lspc_pkg::X_W'(a_prod_reg[lspc_pkg::PROD_W-1:14]);
        if (a_flip_reg) begin
            x0 = -x0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            max_range_reg   <= '1;
            acc_reg         <= '0;
            cnt_reg         <= '0;
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    lspc_pkg::CFG_START_ANGLE: start_angle_reg <= cfg_wdata;
                    lspc_pkg::CFG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata;
                    lspc_pkg::CFG_MAX_RANGE:   max_range_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (accept) begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
            if (adv) begin
                a_valid_reg <= accept && keep;
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_prod_reg        <= lspc_pkg::PROD_W'(range_mm)
                                 * lspc_pkg::PROD_W'(lspc_pkg::GAIN_Q30);
            a_flip_reg        <= flip;
            a_z_reg           <= {{(lspc_pkg::Z_W - lspc_pkg::ANGLE_W - 16)
                                   {res_ang[lspc_pkg::ANGLE_W-1]}}, res_ang, 16'd0};
            a_beam_reg.range  <= range_mm;
            a_beam_reg.angle  <= ang;
            a_beam_reg.number <= idx;
            b_vec_reg.x       <= x0;
            b_vec_reg.y       <= '0;
            b_vec_reg.z       <= a_z_reg;
            b_beam_reg        <= a_beam_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_vec   = b_vec_reg;
    assign out_beam  = b_beam_reg;

endmodule

// File: design/lspc_cell.sv
// ----------------------------------------------------------------------------
// lspc_cell
// One rotation-mode CORDIC iteration with its own register stage.
// ----------------------------------------------------------------------------
module lspc_cell #(
    parameter int SHIFT = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            adv,
    input  logic            in_valid,
    input  lspc_pkg::vec_t  in_vec,
    input  lspc_pkg::beam_t in_beam,
    output logic            out_valid,
    output lspc_pkg::vec_t  out_vec,
    output lspc_pkg::beam_t out_beam
);

    localparam logic signed [lspc_pkg::Z_W-1:0] ATAN =
        lspc_pkg::Z_W'(lspc_pkg::atan_val(SHIFT));

    logic            valid_reg;
    lspc_pkg::vec_t  vec_reg, vec_next;
    lspc_pkg::beam_t beam_reg;

    logic signed [lspc_pkg::X_W-1:0] xs, ys;

    always_comb begin
        xs = in_vec.x >>> SHIFT;
        ys = in_vec.y >>> SHIFT;
        if (in_vec.z[lspc_pkg::Z_W-1]) begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ATAN;
        end else begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            vec_reg  <= vec_next;
            beam_reg <= in_beam;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_beam  = beam_reg;

endmodule

// File: design/laser_scan_polar_to_cartesian.sv
// ----------------------------------------------------------------------------
// laser_scan_polar_to_cartesian
// Converts a stream of laser range samples into beam angle, index and x/y.
//
// Input channel s_*: one range sample per item with a finite flag and a
// scan-start mark. Output channel m_*: one item per kept sample (finite and
// below max_range); dropped samples still advance the beam index and angle.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr
// (0 start_angle, 1 angle_step, 2 max_range); other indexes are ignored.
// Throughput: one item per cycle while the receiver takes results. From input
// accept to output valid an item passes two front stages (gain multiply, quadrant
// fold), one CORDIC cell per stage, and the rounding output register.
// The whole chain moves together; when the receiver stalls with a result
// waiting, the chain holds and s_ready drops until the result is taken.
// Reset (aresetn, synchronous) clears the pipeline, restarts the beam count
// at zero and sets max_range to 65535, the angles to zero.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module laser_scan_polar_to_cartesian #(
    parameter int MAX_BEAMS     = lspc_pkg::MAX_BEAMS_DEF,
    parameter int CORDIC_STAGES = lspc_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [lspc_pkg::RANGE_W-1:0]          s_range_mm,
    input  logic                                  s_range_finite,
    input  logic                                  s_scan_start,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [lspc_pkg::RANGE_W-1:0]          m_beam_range,
    output logic signed [lspc_pkg::ANGLE_W-1:0]   m_beam_angle,
    output logic signed [lspc_pkg::POINT_W-1:0]   m_point_x,
    output logic signed [lspc_pkg::POINT_W-1:0]   m_point_y,
    output logic [lspc_pkg::BEAM_W-1:0]           m_beam_number,
    input  logic                                  cfg_wr_en,
    input  logic [lspc_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [lspc_pkg::CFG_W-1:0]            cfg_wdata
);

    localparam int BEAM_LIMIT = (MAX_BEAMS - 1 > 4095) ? 4095 : MAX_BEAMS - 1;
    localparam logic [lspc_pkg::BEAM_W-1:0] LIMIT = lspc_pkg::BEAM_W'(BEAM_LIMIT);
    localparam int RND_W = lspc_pkg::X_W - 16;

    logic adv;
    logic accept;

    logic            chain_valid [CORDIC_STAGES+1];
    lspc_pkg::vec_t  chain_vec   [CORDIC_STAGES+1];
    lspc_pkg::beam_t chain_beam  [CORDIC_STAGES+1];

    logic                               out_valid_reg;
    lspc_pkg::beam_t                    out_beam_reg;
    logic signed [lspc_pkg::POINT_W-1:0] out_x_reg, out_x_next;
    logic signed [lspc_pkg::POINT_W-1:0] out_y_reg, out_y_next;

    logic signed [lspc_pkg::X_W-1:0] x_rnd, y_rnd;
    logic signed [RND_W-1:0]         x_int, y_int;

    assign adv    = !out_valid_reg || m_ready;
    assign accept = s_valid && s_ready;

    lspc_front #(
        .BEAM_LIMIT (BEAM_LIMIT)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .accept       (accept),
        .range_mm     (s_range_mm),
        .range_finite (s_range_finite),
        .scan_start   (s_scan_start),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .out_valid    (chain_valid[0]),
        .out_vec      (chain_vec[0]),
        .out_beam     (chain_beam[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        lspc_cell #(
            .SHIFT (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .in_beam   (chain_beam[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1]),
            .out_beam  (chain_beam[i+1])
        );
    end

    // round to whole mm and saturate
    always_comb begin
        x_rnd = chain_vec[CORDIC_STAGES].x + lspc_pkg::X_W'(32768);
        y_rnd = chain_vec[CORDIC_STAGES].y + lspc_pkg::X_W'(32768);
        x_int = x_rnd[lspc_pkg::X_W-1:16];
        y_int = y_rnd[lspc_pkg::X_W-1:16];
        if (x_int > RND_W'(lspc_pkg::POINT_MAX)) begin
            out_x_next = lspc_pkg::POINT_MAX;
        end else if (x_int < RND_W'(lspc_pkg::POINT_MIN)) begin
            out_x_next = lspc_pkg::POINT_MIN;
        end else begin
            out_x_next = x_int[lspc_pkg::POINT_W-1:0];
        end
        if (y_int > RND_W'(lspc_pkg::POINT_MAX)) begin
            out_y_next = lspc_pkg::POINT_MAX;
        end else if (y_int < RND_W'(lspc_pkg::POINT_MIN)) begin
            out_y_next = lspc_pkg::POINT_MIN;
        end else begin
            out_y_next = y_int[lspc_pkg::POINT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= chain_valid[CORDIC_STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_beam_reg <= chain_beam[CORDIC_STAGES];
            out_x_reg    <= out_x_next;
            out_y_reg    <= out_y_next;
        end
    end

    assign s_ready       = aresetn && adv;
    assign m_valid       = out_valid_reg;
    assign m_beam_range  = out_beam_reg.range;
    assign m_beam_angle  = out_beam_reg.angle;
    assign m_point_x     = out_x_reg;
    assign m_point_y     = out_y_reg;
    assign m_beam_number = out_beam_reg.number;

    `ASSERT_IMPLY(a_x_sat, aclk, aresetn, m_valid, m_point_x != -17'sd65536)
    `ASSERT_IMPLY(a_y_sat, aclk, aresetn, m_valid, m_point_y != -17'sd65536)
    `ASSERT_IMPLY(a_beam_lim, aclk, aresetn, m_valid, m_beam_number <= LIMIT)
    `ASSERT_IMPLY(a_hold, aclk, aresetn, m_valid && !m_ready, ##1 m_valid)

endmodule

// File: dv/tb_laser_scan_polar_to_cartesian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laser_scan_polar_to_cartesian
// Self-checking bench for the laser scan polar-to-cartesian converter.
//
// A directed table runs first: reset defaults, range and angle extremes,
// quadrant folds, a step change mid-scan, angle wrap, max_range at both ends
// and a write to the unused register index. Next comes one long scan with
// back-to-back items. Random phases with random register settings and scans
// of random length follow. An in-bench CORDIC model predicts every kept
// beam. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_laser_scan_polar_to_cartesian;

    localparam int LATENCY      = lspc_pkg::CORDIC_STAGES_DEF + 3;
    localparam int BEAM_LIMIT   = (lspc_pkg::MAX_BEAMS_DEF - 1 > 4095)
                                  ? 4095 : lspc_pkg::MAX_BEAMS_DEF - 1;
    localparam int RANDOM_ITEMS = 740;
    localparam int LONG_BEAMS   = 300;
    localparam int N_ROWS       = 33;

    localparam logic [lspc_pkg::CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

    // arctan(2^-i), 2^32 units per turn
    localparam longint ATAN_TURN [0:lspc_pkg::ATAN_LEN-1] = '{
        536870912, 316933406, 167458907, 85004756,
        42667331,  21354465,  10680862,  5341269,
        2670675,   1335087,   667544,    333772,
        166886,    83443,     41722,     20861,
        10430,     5215,      2608,      1304,
        652,       326,       163,       81
    };

    typedef struct packed {
        logic [lspc_pkg::RANGE_W-1:0] range;
        logic [lspc_pkg::ANGLE_W-1:0] angle;
        logic [lspc_pkg::POINT_W-1:0] x;
        logic [lspc_pkg::POINT_W-1:0] y;
        logic [lspc_pkg::BEAM_W-1:0]  number;
    } beam_pt_t;

    typedef enum {ROW_ITEM, ROW_WR_START, ROW_WR_STEP, ROW_WR_MAX, ROW_WR_SPARE} row_kind_t;

    // val is the range on item rows, the register value on write rows
    typedef struct {
        row_kind_t kind;
        int        val;
        bit        finite;
        bit        start;
        bit        keep;
        int        angle;
        int        number;
    } row_t;

    logic                                aclk;
    logic                                aresetn        = 1'b0;
    logic                                s_valid        = 1'b0;
    logic                                s_ready;
    logic [lspc_pkg::RANGE_W-1:0]        s_range_mm     = '0;
    logic                                s_range_finite = 1'b0;
    logic                                s_scan_start   = 1'b0;
    logic                                m_valid;
    logic                                m_ready        = 1'b0;
    logic [lspc_pkg::RANGE_W-1:0]        m_beam_range;
    logic signed [lspc_pkg::ANGLE_W-1:0] m_beam_angle;
    logic signed [lspc_pkg::POINT_W-1:0] m_point_x;
    logic signed [lspc_pkg::POINT_W-1:0] m_point_y;
    logic [lspc_pkg::BEAM_W-1:0]         m_beam_number;
    logic                                cfg_wr_en      = 1'b0;
    logic [lspc_pkg::CFG_ADDR_W-1:0]     cfg_addr       = '0;
    logic [lspc_pkg::CFG_W-1:0]          cfg_wdata      = '0;

    // register mirror and beam tracking state
    logic [lspc_pkg::ANGLE_W-1:0] reg_start = '0;
    logic [lspc_pkg::ANGLE_W-1:0] reg_step  = '0;
    logic [lspc_pkg::RANGE_W-1:0] reg_max   = 16'hFFFF;
    logic [lspc_pkg::ANGLE_W-1:0] ang_acc   = '0;
    logic [lspc_pkg::BEAM_W-1:0]  beam_cnt  = '0;

    bit       tx_burst = 1'b0;
    bit       rx_burst = 1'b0;
    int       mismatch_count = 0;
    beam_pt_t expected_points[$];

    row_t directed_rows [N_ROWS] = '{
        '{ROW_ITEM,     1000,   1, 0, 1, 0,      0},
        '{ROW_ITEM,     0,      1, 0, 1, 0,      1},
        '{ROW_ITEM,     65535,  1, 0, 0, 0,      0},
        '{ROW_ITEM,     65534,  1, 0, 1, 0,      3},
        '{ROW_ITEM,     777,    0, 0, 0, 0,      0},
        '{ROW_ITEM,     1234,   1, 1, 1, 0,      0},
        '{ROW_WR_START, 16384,  0, 0, 0, 0,      0},
        '{ROW_WR_STEP,  8192,   0, 0, 0, 0,      0},
        '{ROW_WR_MAX,   40000,  0, 0, 0, 0,      0},
        '{ROW_WR_SPARE, 4660,   0, 0, 0, 0,      0},
        '{ROW_ITEM,     39999,  1, 1, 1, 16384,  0},
        '{ROW_ITEM,     40000,  1, 0, 0, 0,      0},
        '{ROW_ITEM,     20000,  1, 0, 1, -32768, 2},
        '{ROW_ITEM,     65535,  0, 0, 0, 0,      0},
        '{ROW_ITEM,     12345,  1, 0, 1, -16384, 4},
        '{ROW_ITEM,     1,      1, 0, 1, -8192,  5},
        '{ROW_ITEM,     30000,  1, 0, 1, 0,      6},
        '{ROW_ITEM,     30000,  1, 0, 1, 8192,   7},
        '{ROW_WR_STEP,  -32768, 0, 0, 0, 0,      0},
        '{ROW_ITEM,     5000,   1, 0, 1, 16384,  8},
        '{ROW_ITEM,     5000,   1, 0, 1, -16384, 9},
        '{ROW_WR_START, 32767,  0, 0, 0, 0,      0},
        '{ROW_WR_STEP,  32767,  0, 0, 0, 0,      0},
        '{ROW_WR_MAX,   0,      0, 0, 0, 0,      0},
        '{ROW_ITEM,     0,      1, 1, 0, 0,      0},
        '{ROW_ITEM,     100,    1, 0, 0, 0,      0},
        '{ROW_WR_MAX,   65535,  0, 0, 0, 0,      0},
        '{ROW_ITEM,     65534,  1, 0, 1, 32765,  2},
        '{ROW_ITEM,     65534,  1, 0, 1, -4,     3},
        '{ROW_WR_START, -32768, 0, 0, 0, 0,      0},
        '{ROW_WR_STEP,  -32768, 0, 0, 0, 0,      0},
        '{ROW_ITEM,     4321,   1, 1, 1, -32768, 0},
        '{ROW_ITEM,     4321,   1, 0, 1, 0,      1}
    };

    laser_scan_polar_to_cartesian DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_range_mm     (s_range_mm),
        .s_range_finite (s_range_finite),
        .s_scan_start   (s_scan_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_beam_range   (m_beam_range),
        .m_beam_angle   (m_beam_angle),
        .m_point_x      (m_point_x),
        .m_point_y      (m_point_y),
        .m_beam_number  (m_beam_number),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("tb_laser_scan_polar_to_cartesian: FAIL");
        $finish;
    end

    function automatic void add_expected(input beam_pt_t pt);
        expected_points = {expected_points, pt};
    endfunction

    function automatic logic [lspc_pkg::POINT_W-1:0] round_clamp(input longint v);
        longint q;
        q = (v + 32768) >>> 16;
        if (q > 65535)
            q = 65535;
        if (q < -65535)
            q = -65535;
        return q[lspc_pkg::POINT_W-1:0];
    endfunction

    // rotation-mode CORDIC on a gain-compensated start vector
    function automatic void rotate_range(input logic [lspc_pkg::RANGE_W-1:0] r,
                                         input logic [lspc_pkg::ANGLE_W-1:0] ang,
                                         output logic [lspc_pkg::POINT_W-1:0] px,
                                         output logic [lspc_pkg::POINT_W-1:0] py);
        longint x, y, z, xs, ys;
        int     res;
        x = (longint'(r) * longint'(lspc_pkg::GAIN_Q30)) >>> 14;
        y = 0;
        if (ang >= 16'd16384 && ang < 16'd49152) begin
            x = -x;
            res = int'(ang) - 32768;
        end else begin
            res = int'($signed(ang));
        end
        z = longint'(res) * 65536;
        for (int i = 0; i < lspc_pkg::CORDIC_STAGES_DEF && i < lspc_pkg::ATAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_TURN[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_TURN[i];
            end
        end
        px = round_clamp(x);
        py = round_clamp(y);
    endfunction

    // advances beam index and angle; returns 1 when the beam is kept
    function automatic bit predict_beam(input logic [lspc_pkg::RANGE_W-1:0] r,
                                        input bit finite, input bit start,
                                        output beam_pt_t pt);
        logic [lspc_pkg::BEAM_W-1:0]  idx;
        logic [lspc_pkg::ANGLE_W-1:0] off;
        logic [lspc_pkg::ANGLE_W-1:0] ang;
        idx = start ? '0 : beam_cnt;
        off = start ? '0 : ang_acc;
        ang = reg_start + off;
        if (idx < BEAM_LIMIT) begin
            beam_cnt = idx + 1'b1;
            ang_acc  = off + reg_step;
        end else begin
            beam_cnt = idx;
            ang_acc  = off;
        end
        pt.range  = r;
        pt.angle  = ang;
        pt.number = idx;
        rotate_range(r, ang, pt.x, pt.y);
        return finite && (r < reg_max);
    endfunction

    function automatic logic [lspc_pkg::ANGLE_W-1:0] pick_angle();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [lspc_pkg::RANGE_W-1:0] pick_max_range();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'd1;
            3: return 16'hFFFE;
            default: return 16'($urandom_range(1024, 65535));
        endcase
    endfunction

    task automatic send_beam(input logic [lspc_pkg::RANGE_W-1:0] r, input bit finite,
                             input bit start, output bit keep, output beam_pt_t pt);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_range_mm     <= r;
        s_range_finite <= finite;
        s_scan_start   <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        keep = predict_beam(r, finite, start, pt);
    endtask

    task automatic send_checked(input logic [lspc_pkg::RANGE_W-1:0] r, input bit finite,
                                input bit start);
        bit       keep;
        beam_pt_t pt;
        send_beam(r, finite, start, keep, pt);
        if (keep)
            add_expected(pt);
    endtask

    task automatic cfg_write(input logic [lspc_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [lspc_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            lspc_pkg::CFG_START_ANGLE: reg_start = val;
            lspc_pkg::CFG_ANGLE_STEP:  reg_step  = val;
            lspc_pkg::CFG_MAX_RANGE:   reg_max   = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // dropped beams leave no result, so also let the pipe run empty
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : point_check
        beam_pt_t want;
        beam_pt_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_beam_range, m_beam_angle, m_point_x, m_point_y, m_beam_number};
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: range %0d angle %0d x %0d y %0d beam %0d",
                             got.range, $signed(got.angle), $signed(got.x),
                             $signed(got.y), got.number);
            end else begin
                want = expected_points.pop_front();
                if (want.range !== got.range || want.angle !== got.angle ||
                    want.x !== got.x || want.y !== got.y || want.number !== got.number) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("exp/got rng %0d/%0d ang %0d/%0d x %0d/%0d y %0d/%0d n %0d/%0d",
                                 want.range, got.range, $signed(want.angle),
                                 $signed(got.angle), $signed(want.x), $signed(got.x),
                                 $signed(want.y), $signed(got.y), want.number, got.number);
                end
            end
        end
    end

    initial begin
        row_t     row;
        bit       keep;
        beam_pt_t pt;
        int       random_sent;
        int       scans;
        int       len;
        bit       fin;
        bit       st;
        logic [lspc_pkg::RANGE_W-1:0] r;

        random_sent = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            case (row.kind)
                ROW_WR_START: begin
                    wait_drained();
                    cfg_write(lspc_pkg::CFG_START_ANGLE, 16'(row.val));
                end
                ROW_WR_STEP: begin
                    wait_drained();
                    cfg_write(lspc_pkg::CFG_ANGLE_STEP, 16'(row.val));
                end
                ROW_WR_MAX: begin
                    wait_drained();
                    cfg_write(lspc_pkg::CFG_MAX_RANGE, 16'(row.val));
                end
                ROW_WR_SPARE: begin
                    wait_drained();
                    cfg_write(CFG_SPARE, 16'(row.val));
                end
                default: begin
                    send_beam(16'(row.val), row.finite, row.start, keep, pt);
                    if (row.keep) begin
                        pt.range  = 16'(row.val);
                        pt.angle  = 16'(row.angle);
                        pt.number = 12'(row.number);
                        add_expected(pt);
                    end
                end
            endcase
        end

        // one long scan, items back to back
        wait_drained();
        cfg_write(lspc_pkg::CFG_START_ANGLE, pick_angle());
        cfg_write(lspc_pkg::CFG_ANGLE_STEP, pick_angle());
        cfg_write(lspc_pkg::CFG_MAX_RANGE, 16'hFFFF);
        tx_burst = 1'b1;
        for (int b = 0; b < LONG_BEAMS; b++) begin
            fin = (b < 4) || (b >= LONG_BEAMS - 8) || ($urandom_range(0, 15) == 0);
            send_checked(16'($urandom_range(0, 65534)), fin, b == 0);
        end
        send_checked(16'($urandom_range(0, 65534)), 1'b1, 1'b1);
        tx_burst = 1'b0;

        while (random_sent < RANDOM_ITEMS) begin
            wait_drained();
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            cfg_write(lspc_pkg::CFG_START_ANGLE, pick_angle());
            if ($urandom_range(0, 3) != 0)
                cfg_write(lspc_pkg::CFG_ANGLE_STEP, pick_angle());
            cfg_write(lspc_pkg::CFG_MAX_RANGE, pick_max_range());
            if ($urandom_range(0, 5) == 0)
                cfg_write(CFG_SPARE, 16'($urandom));
            scans = $urandom_range(1, 5);
            for (int s = 0; s < scans; s++) begin
                len = $urandom_range(1, 60);
                for (int b = 0; b < len; b++) begin
                    if (b == 0)
                        st = (s > 0) || ($urandom_range(0, 3) != 0);
                    else
                        st = ($urandom_range(0, 39) == 0);
                    fin = ($urandom_range(0, 9) != 0);
                    if (reg_max > 0 && $urandom_range(0, 3) != 0)
                        r = 16'($urandom_range(0, reg_max - 1));
                    else
                        r = 16'($urandom);
                    send_checked(r, fin, st);
                    random_sent++;
                    if ($urandom_range(0, 59) == 0)
                        wait_drained();
                end
            end
        end

        s_valid <= 1'b0;
        for (int n = 0; n < 5000 && expected_points.size() != 0; n++) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
        mismatch_count += expected_points.size();
        if (mismatch_count == 0)
            $display("tb_laser_scan_polar_to_cartesian: PASS");
        else
            $display("tb_laser_scan_polar_to_cartesian: FAIL");
        $finish;
    end

endmodule
